// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers clocked on clk with async reset rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// overlapping implication outside reset
`define ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication outside reset
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- hw/rtl/hcd_pkg.sv -----
// ----------------------------------------------------------------------------
// hcd_pkg
// shared types, constants and helpers of the chunked body decoder
// ----------------------------------------------------------------------------
`default_nettype none

package hcd_pkg;

    // size field limits
    localparam int MAX_HEX_DIGITS = 16;
    localparam int DC_W           = $clog2(MAX_HEX_DIGITS + 1);
    localparam int SIZE_W         = 64;
    localparam logic [SIZE_W-1:0] SIZE_LIMIT  = 64'h7fff_ffff_ffff_ffff;
    localparam logic [SIZE_W-1:0] SHIFT_LIMIT = SIZE_LIMIT >> 4;

    // line bytes
    localparam logic [7:0] BYTE_LF = 8'h0a;
    localparam logic [7:0] BYTE_CR = 8'h0d;

    // result kind codes
    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_BODY     = 2'd1;
    localparam logic [1:0] KIND_TRAILER  = 2'd2;
    localparam logic [1:0] KIND_LEFTOVER = 2'd3;

    // status codes
    localparam logic [1:0] STAT_DECODING = 2'd0;
    localparam logic [1:0] STAT_COMPLETE = 2'd1;
    localparam logic [1:0] STAT_FAILED   = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_TOO_LONG  = 2'd1;
    localparam logic [1:0] ERR_BAD_HEX   = 2'd2;
    localparam logic [1:0] ERR_MALFORMED = 2'd3;

    // configuration register indexes
    localparam logic REG_DROP_BODY = 1'b0;
    localparam logic REG_PASS_RAW  = 1'b1;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // parser states
    typedef enum logic [9:0] {
        ST_HEX           = 10'b00_0000_0001,
        ST_EXT           = 10'b00_0000_0010,
        ST_DATA          = 10'b00_0000_0100,
        ST_AFTER_DATA    = 10'b00_0000_1000,
        ST_TRAILER       = 10'b00_0001_0000,
        ST_TR_LF         = 10'b00_0010_0000,
        ST_TR_LINE_START = 10'b00_0100_0000,
        ST_FINAL_LF      = 10'b00_1000_0000,
        ST_DONE          = 10'b01_0000_0000,
        ST_FAILED        = 10'b10_0000_0000
    } hcd_state_t;

    // one queued result; pair marks a synthesized CR LF line end
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       pair;
        logic [1:0] status;
        logic [1:0] error;
    } hcd_entry_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hcd_hex_t;

    // ascii hex digit decode
    function automatic hcd_hex_t hex_decode(input logic [7:0] c);
        hcd_hex_t h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            h.value = c[3:0];
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            h.value = c[3:0] + 4'd9;
        end
        else
        begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/http_chunked_decoder_top.sv -----
// ----------------------------------------------------------------------------
// http_chunked_decoder_top - chunked body decoder, one byte per transfer
// results of a byte are registered in the result queue before they are offered
// throughput: 1 byte per cycle while the queue is not full; a trailer line end is sent as CR then LF
// reset: async active low, clears parser state, config registers and queue
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module http_chunked_decoder_top (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        wr_en,
    input  wire        wr_index,
    input  wire        wr_data,
    input  wire        in_valid,
    output logic       in_ready,
    input  wire [7:0]  data_byte,
    output logic       out_valid,
    input  wire        out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] kind,
    output logic       last,
    output logic [1:0] status,
    output logic [1:0] error
);
    import hcd_pkg::*;

    logic       push;
    hcd_entry_t push_entry;
    logic       queue_full;
    logic       pop;
    logic       head_valid;
    hcd_entry_t head_entry;

    // parser
    hcd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // result queue
    hcd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // output sequencer
    hcd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .kind       (kind),
        .last       (last),
        .status     (status),
        .error      (error)
    );

    // result stream checks
    `ASSERT_IMPLY(a_empty_alone, out_valid && kind == KIND_NONE, last, "kind 0 result not last")
    `ASSERT_IMPLY(a_only_cr_first, out_valid && !last, kind == KIND_TRAILER && out_byte == BYTE_CR, "non-last result is not a trailer CR")
    `ASSERT_IMPLY(a_failed_no_trailer, out_valid && status == STAT_FAILED, kind != KIND_TRAILER && kind != KIND_LEFTOVER, "trailer or leftover after failure")
    `ASSERT_NEXT(a_lf_follows, out_valid && out_ready && !last, out_valid && last && out_byte == BYTE_LF, "line end LF missing")

endmodule

`default_nettype wire

// ----- hw/rtl/hcd_queue.sv -----
// ----------------------------------------------------------------------------
// hcd_queue
// short result queue between the parser and the output sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module hcd_queue (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  hcd_pkg::hcd_entry_t  push_entry,
    output logic                 full,
    input  wire                  pop,
    output logic                 head_valid,
    output hcd_pkg::hcd_entry_t  head_entry
);
    import hcd_pkg::*;

    hcd_entry_t            slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;

    // occupancy flags and head
    assign full       = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QUEUE_AW+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/hcd_front.sv -----
// ----------------------------------------------------------------------------
// hcd_front
// byte parser: takes one byte per transfer, tracks framing and builds results
// ----------------------------------------------------------------------------
`default_nettype none

module hcd_front (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  wr_en,
    input  wire                  wr_index,
    input  wire                  wr_data,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire [7:0]            data_byte,
    input  wire                  queue_full,
    output logic                 push,
    output hcd_pkg::hcd_entry_t  push_entry
);
    import hcd_pkg::*;

    logic              drop_body_reg;
    logic              pass_raw_reg;
    hcd_state_t        state_reg, state_next;
    logic [DC_W-1:0]   dc_reg, dc_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic              ovf_reg, ovf_next;
    logic              open_reg, open_next;
    logic [1:0]        err_reg, err_next;

    hcd_hex_t          hex;
    logic              is_lf;
    logic              is_cr;
    logic              size_zero;
    logic              size_last;
    logic              raw_emit;
    logic              dec_emit;
    hcd_entry_t        res;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    assign hex       = hex_decode(data_byte);
    assign is_lf     = (data_byte == BYTE_LF);
    assign is_cr     = (data_byte == BYTE_CR);
    assign size_zero = (size_reg == '0);
    assign size_last = (size_reg == SIZE_W'(1)) || size_zero;
    assign raw_emit  = pass_raw_reg && !drop_body_reg;
    assign dec_emit  = !pass_raw_reg && !drop_body_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_body_reg <= 1'b0;
            pass_raw_reg  <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_DROP_BODY: drop_body_reg <= wr_data;
                REG_PASS_RAW:  pass_raw_reg  <= wr_data;
                default:       ;
            endcase
        end
    end

    // parse one byte
    always_comb
    begin
        state_next = state_reg;
        dc_next    = dc_reg;
        size_next  = size_reg;
        ovf_next   = ovf_reg;
        open_next  = open_reg;
        err_next   = err_reg;
        res.data   = 8'd0;
        res.kind   = KIND_NONE;
        res.pair   = 1'b0;

        // raw pass-through ahead of decoding
        if (raw_emit && state_reg != ST_DONE && state_reg != ST_FAILED)
        begin
            res.data = data_byte;
            res.kind = KIND_BODY;
        end

        case (state_reg)
            ST_HEX:
            begin
                if (hex.valid)
                begin
                    if (dc_reg >= DC_W'(MAX_HEX_DIGITS))
                    begin
                        state_next = ST_FAILED;
                        err_next   = ERR_TOO_LONG;
                    end
                    else
                    begin
                        if (size_reg > SHIFT_LIMIT)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            size_next = {size_reg[SIZE_W-5:0], hex.value};
                        end
                        dc_next = dc_reg + DC_W'(1);
                    end
                end
                else if (dc_reg == '0 || ovf_reg)
                begin
                    state_next = ST_FAILED;
                    err_next   = ERR_BAD_HEX;
                end
                else if (is_lf)
                begin
                    state_next = size_zero ? ST_TRAILER : ST_DATA;
                end
                else
                begin
                    state_next = ST_EXT;
                end
            end
            ST_EXT:
            begin
                if (is_lf)
                begin
                    state_next = size_zero ? ST_TRAILER : ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (dec_emit)
                begin
                    res.data = data_byte;
                    res.kind = KIND_BODY;
                end
                if (!size_zero)
                begin
                    size_next = size_reg - SIZE_W'(1);
                end
                if (size_last)
                begin
                    state_next = ST_AFTER_DATA;
                end
            end
            ST_AFTER_DATA:
            begin
                if (is_lf)
                begin
                    state_next = ST_HEX;
                    dc_next    = '0;
                    size_next  = '0;
                    ovf_next   = 1'b0;
                end
                else if (!is_cr)
                begin
                    state_next = ST_FAILED;
                    err_next   = ERR_MALFORMED;
                end
            end
            ST_TRAILER:
            begin
                if (is_cr || is_lf)
                begin
                    if (open_reg)
                    begin
                        if (!pass_raw_reg)
                        begin
                            res.kind = KIND_TRAILER;
                            res.pair = 1'b1;
                        end
                        open_next  = 1'b0;
                        state_next = is_cr ? ST_TR_LF : ST_TR_LINE_START;
                    end
                    else
                    begin
                        state_next = is_cr ? ST_FINAL_LF : ST_DONE;
                    end
                end
                else
                begin
                    if (!pass_raw_reg)
                    begin
                        res.data = data_byte;
                        res.kind = KIND_TRAILER;
                    end
                    open_next = 1'b1;
                end
            end
            ST_TR_LF:
            begin
                if (is_lf)
                begin
                    state_next = ST_TR_LINE_START;
                end
                else
                begin
                    state_next = ST_FAILED;
                    err_next   = ERR_MALFORMED;
                end
            end
            ST_TR_LINE_START:
            begin
                if (is_cr)
                begin
                    state_next = ST_FINAL_LF;
                end
                else if (is_lf)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    if (!pass_raw_reg)
                    begin
                        res.data = data_byte;
                        res.kind = KIND_TRAILER;
                    end
                    open_next  = 1'b1;
                    state_next = ST_TRAILER;
                end
            end
            ST_FINAL_LF:
            begin
                if (is_lf)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_FAILED;
                    err_next   = ERR_MALFORMED;
                end
            end
            ST_DONE:
            begin
                res.data = data_byte;
                res.kind = KIND_LEFTOVER;
            end
            ST_FAILED:
            begin
            end
            default:
            begin
                state_next = ST_FAILED;
                err_next   = ERR_MALFORMED;
            end
        endcase

        // status after this byte
        case (state_next)
            ST_DONE:   res.status = STAT_COMPLETE;
            ST_FAILED: res.status = STAT_FAILED;
            default:   res.status = STAT_DECODING;
        endcase
        res.error = err_next;
    end

    assign push_entry = res;

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HEX;
            dc_reg    <= '0;
            size_reg  <= '0;
            ovf_reg   <= 1'b0;
            open_reg  <= 1'b0;
            err_reg   <= ERR_NONE;
        end
        else if (push)
        begin
            state_reg <= state_next;
            dc_reg    <= dc_next;
            size_reg  <= size_next;
            ovf_reg   <= ovf_next;
            open_reg  <= open_next;
            err_reg   <= err_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/hcd_back.sv -----
// ----------------------------------------------------------------------------
// hcd_back
// output sequencer: drives queued results, expanding line ends into CR and LF
// ----------------------------------------------------------------------------
`default_nettype none

module hcd_back (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  head_valid,
    input  hcd_pkg::hcd_entry_t  head_entry,
    output logic                 pop,
    output logic                 out_valid,
    input  wire                  out_ready,
    output logic [7:0]           out_byte,
    output logic [1:0]           kind,
    output logic                 last,
    output logic [1:0]           status,
    output logic [1:0]           error
);
    import hcd_pkg::*;

    // high while the LF half of a line end is on the port
    logic phase_reg, phase_next;
    logic xfer;

    assign out_valid = head_valid;
    assign xfer      = out_valid && out_ready;
    assign pop       = xfer && (!head_entry.pair || phase_reg);

    // result fields
    always_comb
    begin
        kind   = head_entry.kind;
        status = head_entry.status;
        error  = head_entry.error;
        if (head_entry.pair)
        begin
            out_byte = phase_reg ? BYTE_LF : BYTE_CR;
            last     = phase_reg;
        end
        else
        begin
            out_byte = head_entry.data;
            last     = 1'b1;
        end
    end

    // line end phase
    always_comb
    begin
        phase_next = phase_reg;
        if (xfer && head_entry.pair)
        begin
            phase_next = !phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire
